[hdl/ssc_pkg.sv]
// shared constants for the sponge cipher engine
`default_nettype none
package ssc_pkg;
    localparam logic [2:0] MODE_INIT  = 3'd0;
    localparam logic [2:0] MODE_ABS   = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_SHUF  = 3'd3;
    localparam logic [2:0] MODE_DRIP  = 3'd4;
    localparam logic [2:0] MODE_ADD   = 3'd5;
    localparam logic [2:0] MODE_SUB   = 3'd6;
    localparam logic [2:0] MODE_XOR   = 3'd7;
    localparam logic [7:0] HALF       = 8'd128;
    localparam int         WHIP_ROUNDS = 512;
endpackage
`default_nettype wire

[hdl/spritz_sponge_cipher.sv]
// sponge cipher engine over a 256-byte permutation held in one ram
`default_nettype none
// Sponge engine over a 256-entry byte permutation kept in a single-port RAM
// with registered read. One item is taken at a time; s_tready is low while it
// is worked on and while its result item waits on the master side. After
// reset, and after an init item, a clearing pass writes the identity
// permutation. The time a keystream byte (drip or crypt) takes is set by the
// chain of dependent reads and the swap through the one RAM port. A shuffle
// runs whip, crush, whip, crush, whip. Every item gives one result item on the
// master side, held in an output register until it is taken. The next item
// is accepted no earlier than the cycle after that.
module spritz_sponge_cipher
    import ssc_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [15:0] s_tdata,   // mode[2:0], data_byte[10:3], zero fill
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [15:0] m_tdata   // out_byte[7:0], out_valid[8], zero fill
);
    // state codes
    localparam logic [4:0] S_IDLE = 5'd0,  S_CLR = 5'd1,  S_DISP = 5'd2,
        S_ABS0 = 5'd3, S_ABS1 = 5'd4, S_ABS2 = 5'd5, S_ABS3 = 5'd6,
        S_U0 = 5'd7, S_U1 = 5'd8, S_U2 = 5'd9, S_U3 = 5'd10, S_U4 = 5'd11,
        S_U5 = 5'd12, S_U6 = 5'd13, S_U7 = 5'd14,
        S_C0 = 5'd15, S_C1 = 5'd16, S_C2 = 5'd17, S_C3 = 5'd18,
        S_K0 = 5'd19, S_K1 = 5'd20, S_K2 = 5'd21, S_K3 = 5'd22,
        S_K4 = 5'd23, S_K5 = 5'd24, S_DONE = 5'd25, S_OUT = 5'd26;

    logic [7:0] perm_mem [0:255];
    logic [7:0] rd_q;
    logic       we;
    logic [7:0] addr, wdata;

    logic [4:0] state_reg, state_next;
    logic [2:0] mode_reg, mode_next;
    logic [7:0] data_reg, data_next;
    logic [7:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, z_reg, z_next;
    logic [7:0] a_reg, a_next, w_reg, w_next;
    logic [7:0] t0_reg, t0_next, t1_reg, t1_next;
    logic [9:0] cnt_reg, cnt_next;
    logic [2:0] phase_reg, phase_next;   // shuffle phase 0..4, 5 when done
    logic       shuf_reg, shuf_next;     // update belongs to a shuffle
    logic       nib_reg, nib_next;       // second nibble of absorb
    logic [7:0] res_reg, res_next;
    logic       ov_reg, ov_next;
    logic       mv_reg, mv_next;

    // ram with registered read
    always_ff @(posedge aclk) begin
        if (we) perm_mem[addr] <= wdata;
        rd_q <= perm_mem[addr];
    end

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {7'd0, ov_reg, res_reg};

    // sequencer
    always_comb begin
        state_next = state_reg; mode_next = mode_reg; data_next = data_reg;
        i_next = i_reg; j_next = j_reg; k_next = k_reg; z_next = z_reg;
        a_next = a_reg; w_next = w_reg; t0_next = t0_reg; t1_next = t1_reg;
        cnt_next = cnt_reg; phase_next = phase_reg; shuf_next = shuf_reg;
        nib_next = nib_reg; res_next = res_reg; ov_next = ov_reg;
        mv_next = mv_reg; we = 1'b0; addr = 8'd0; wdata = 8'd0;
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && !mv_reg) begin
                    mode_next = s_tdata[2:0];
                    data_next = s_tdata[10:3];
                    nib_next = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_CLR: begin
                // identity fill, one entry a cycle; only an init item answers
                we = 1'b1; addr = cnt_reg[7:0]; wdata = cnt_reg[7:0];
                cnt_next = cnt_reg + 10'd1;
                if (cnt_reg[7:0] == 8'hff)
                    state_next = (mode_reg == MODE_INIT) ? S_DONE : S_IDLE;
            end
            S_DISP: begin
                shuf_next = 1'b0;
                case (mode_reg)
                    MODE_INIT: begin
                        i_next = 8'd0; j_next = 8'd0; k_next = 8'd0;
                        z_next = 8'd0; a_next = 8'd0; w_next = 8'd1;
                        cnt_next = 10'd0; state_next = S_CLR;
                    end
                    MODE_ABS, MODE_STOP: begin
                        if (a_reg == HALF) begin
                            shuf_next = 1'b1; phase_next = 3'd0;
                            cnt_next = 10'd0; state_next = S_U0;
                        end else if (mode_reg == MODE_STOP) begin
                            a_next = a_reg + 8'd1; state_next = S_DONE;
                        end else begin
                            state_next = S_ABS0;
                        end
                    end
                    MODE_SHUF, MODE_DRIP: begin
                        if (a_reg != 8'd0) begin
                            shuf_next = 1'b1; phase_next = 3'd0;
                            cnt_next = 10'd0; state_next = S_U0;
                        end else if (mode_reg == MODE_SHUF) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_U0;
                        end
                    end
                    default: state_next = S_U0;
                endcase
            end
            // swap perm[a] with perm[128 + nibble]
            S_ABS0: begin addr = a_reg; state_next = S_ABS1; end
            S_ABS1: begin
                t0_next = rd_q;
                addr = HALF | {4'd0, nib_reg ? data_reg[7:4] : data_reg[3:0]};
                state_next = S_ABS2;
            end
            S_ABS2: begin
                we = 1'b1; addr = a_reg; wdata = rd_q; state_next = S_ABS3;
            end
            S_ABS3: begin
                we = 1'b1; wdata = t0_reg;
                addr = HALF | {4'd0, nib_reg ? data_reg[7:4] : data_reg[3:0]};
                a_next = a_reg + 8'd1;
                if (nib_reg) state_next = S_DONE;
                else begin nib_next = 1'b1; state_next = S_DISP; end
            end
            // update: i += w; j = k + S[j + S[i]]; k += i + S[j]; swap
            S_U0: begin
                i_next = i_reg + w_reg; addr = i_reg + w_reg; state_next = S_U1;
            end
            S_U1: begin
                t0_next = rd_q; addr = j_reg + rd_q; state_next = S_U2;
            end
            S_U2: begin
                j_next = k_reg + rd_q; addr = k_reg + rd_q; state_next = S_U3;
            end
            S_U3: begin
                t1_next = rd_q; k_next = k_reg + i_reg + rd_q;
                we = 1'b1; addr = i_reg; wdata = rd_q; state_next = S_U4;
            end
            S_U4: begin
                we = 1'b1; addr = j_reg; wdata = t0_reg;
                state_next = shuf_reg ? S_U5 : S_K0;
            end
            S_U5: begin
                cnt_next = cnt_reg + 10'd1;
                state_next = S_U0;
                if (cnt_reg == 10'(WHIP_ROUNDS - 1)) begin
                    w_next = w_reg + 8'd2; cnt_next = 10'd0;
                    phase_next = phase_reg + 3'd1;
                    state_next = (phase_reg == 3'd4) ? S_U6 : S_C0;
                end
            end
            S_U6: begin
                // shuffle finished: clear count, resume the item
                a_next = 8'd0; shuf_next = 1'b0; state_next = S_U7;
            end
            S_U7: begin
                case (mode_reg)
                    MODE_SHUF: state_next = S_DONE;
                    MODE_DRIP: state_next = S_U0;
                    default:   state_next = S_DISP;
                endcase
            end
            // crush: conditional swap of v and 255-v
            S_C0: begin addr = cnt_reg[7:0]; state_next = S_C1; end
            S_C1: begin
                t0_next = rd_q; addr = ~cnt_reg[7:0]; state_next = S_C2;
            end
            S_C2: begin
                t1_next = rd_q;
                if (t0_reg > rd_q) begin
                    we = 1'b1; addr = cnt_reg[7:0]; wdata = rd_q;
                    state_next = S_C3;
                end else state_next = S_C3;
            end
            S_C3: begin
                if (t0_reg > t1_reg) begin
                    we = 1'b1; addr = ~cnt_reg[7:0]; wdata = t0_reg;
                end
                cnt_next = cnt_reg + 10'd1; state_next = S_C0;
                if (cnt_reg == 10'(HALF - 1)) begin
                    cnt_next = 10'd0; phase_next = phase_reg + 3'd1;
                    state_next = S_U0;
                end
            end
            // output: z = S[j + S[i + S[z + k]]]
            S_K0: begin addr = z_reg + k_reg; state_next = S_K1; end
            S_K1: begin addr = i_reg + rd_q; state_next = S_K2; end
            S_K2: begin addr = j_reg + rd_q; state_next = S_K3; end
            S_K3: begin t1_next = rd_q; state_next = S_K4; end
            S_K4: begin
                z_next = t1_reg;
                case (mode_reg)
                    MODE_ADD: res_next = data_reg + t1_reg;
                    MODE_SUB: res_next = data_reg - t1_reg;
                    MODE_XOR: res_next = data_reg ^ t1_reg;
                    default:  res_next = t1_reg;
                endcase
                ov_next = 1'b1; state_next = S_OUT;
            end
            S_DONE: begin
                res_next = 8'd0; ov_next = 1'b0; state_next = S_OUT;
            end
            S_OUT: begin
                if (!mv_reg) begin mv_next = 1'b1; state_next = S_IDLE; end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR; cnt_reg <= 10'd0; mv_reg <= 1'b0;
            i_reg <= 8'd0; j_reg <= 8'd0; k_reg <= 8'd0; z_reg <= 8'd0;
            a_reg <= 8'd0; w_reg <= 8'd1; phase_reg <= 3'd0;
            shuf_reg <= 1'b0; nib_reg <= 1'b0; mode_reg <= MODE_SHUF;
        end else begin
            state_reg <= state_next; cnt_reg <= cnt_next; mv_reg <= mv_next;
            i_reg <= i_next; j_reg <= j_next; k_reg <= k_next; z_reg <= z_next;
            a_reg <= a_next; w_reg <= w_next; phase_reg <= phase_next;
            shuf_reg <= shuf_next; nib_reg <= nib_next; mode_reg <= mode_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        data_reg <= data_next; t0_reg <= t0_next; t1_reg <= t1_next;
        res_reg <= res_next; ov_reg <= ov_next;
    end
endmodule
`default_nettype wire

[tb/spritz_sponge_cipher_tb.sv]
// self-checking testbench for the sponge cipher engine with its own state predictor
`default_nettype none
module spritz_sponge_cipher_tb;
    import ssc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
    } cipher_res_t;

    localparam int WATCHDOG_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    // predictor state
    logic [7:0] sbox [256];
    logic [7:0] pi, pj, pk, pz, pa, pw;

    cipher_res_t expected_q[$];
    int          mismatches;
    int          send_gap_pct;
    int          recv_stall_pct;
    int          idle_cycles;
    bit          timed_out;

    spritz_sponge_cipher uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // predictor
    function automatic void sbox_swap(logic [7:0] p, logic [7:0] q);
        logic [7:0] t;
        t = sbox[p];
        sbox[p] = sbox[q];
        sbox[q] = t;
    endfunction

    function automatic void state_clear();
        for (int v = 0; v < 256; v++) sbox[v] = v[7:0];
        pi = 8'd0; pj = 8'd0; pk = 8'd0; pz = 8'd0; pa = 8'd0; pw = 8'd1;
    endfunction

    function automatic void state_update();
        pi = pi + pw;
        pj = pk + sbox[8'(pj + sbox[pi])];
        pk = pk + pi + sbox[pj];
        sbox_swap(pi, pj);
    endfunction

    function automatic void state_whip();
        for (int r = 0; r < WHIP_ROUNDS; r++) state_update();
        pw = pw + 8'd2;
    endfunction

    function automatic void state_crush();
        for (int v = 0; v < 128; v++)
            if (sbox[v] > sbox[255 - v]) sbox_swap(v[7:0], 8'(255 - v));
    endfunction

    function automatic void state_shuffle();
        state_whip(); state_crush(); state_whip(); state_crush(); state_whip();
        pa = 8'd0;
    endfunction

    function automatic void absorb_half(logic [3:0] x);
        if (pa == HALF) state_shuffle();
        sbox_swap(pa, HALF + {4'd0, x});
        pa = pa + 8'd1;
    endfunction

    function automatic logic [7:0] keystream_next();
        logic [7:0] r;
        state_update();
        r = pz + pk;
        r = pi + sbox[r];
        r = pj + sbox[r];
        pz = sbox[r];
        return pz;
    endfunction

    function automatic cipher_res_t predict_item(logic [2:0] mode, logic [7:0] b);
        cipher_res_t res;
        res = '0;
        case (mode)
            MODE_INIT: state_clear();
            MODE_ABS: begin
                absorb_half(b[3:0]);
                absorb_half(b[7:4]);
            end
            MODE_STOP: begin
                if (pa == HALF) state_shuffle();
                pa = pa + 8'd1;
            end
            MODE_SHUF: if (pa != 0) state_shuffle();
            MODE_DRIP: begin
                if (pa != 0) state_shuffle();
                res.out_byte = keystream_next();
                res.out_valid = 1'b1;
            end
            MODE_ADD: begin
                res.out_byte = b + keystream_next();
                res.out_valid = 1'b1;
            end
            MODE_SUB: begin
                res.out_byte = b - keystream_next();
                res.out_valid = 1'b1;
            end
            default: begin
                res.out_byte = b ^ keystream_next();
                res.out_valid = 1'b1;
            end
        endcase
        return res;
    endfunction

    // send one item, with random gap before it
    task automatic send_item(logic [2:0] mode, logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, b, mode};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_item(mode, b));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0 && !timed_out) @(posedge aclk);
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            cipher_res_t want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", m_tdata);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[7:0] !== want.out_byte || m_tdata[8] !== want.out_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: out_byte exp %h got %h, out_valid exp %b got %b",
                                 want.out_byte, m_tdata[7:0], want.out_valid, m_tdata[8]);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("** spritz_sponge_cipher: FAILED **");
            $finish;
        end
    end

    // directed: no-output modes, absorb extremes, stop, drip and crypt
    task automatic test_directed();
        send_item(MODE_DRIP, 8'h00);
        send_item(MODE_ADD, 8'hff);
        send_item(MODE_SUB, 8'h00);
        send_item(MODE_XOR, 8'hff);
        send_item(MODE_SHUF, 8'h00);
        send_item(MODE_ABS, 8'h00);
        send_item(MODE_ABS, 8'hff);
        send_item(MODE_STOP, 8'h5a);
        send_item(MODE_ABS, 8'ha5);
        send_item(MODE_SHUF, 8'h00);
        send_item(MODE_SHUF, 8'h00);
        send_item(MODE_ABS, 8'h3c);
        send_item(MODE_DRIP, 8'h00);
        send_item(MODE_ADD, 8'h80);
        send_item(MODE_SUB, 8'h7f);
        send_item(MODE_XOR, 8'h01);
        send_item(MODE_INIT, 8'hff);
        send_item(MODE_XOR, 8'h00);
    endtask

    // full absorb: 64 bytes fill the half, the next nibble forces a shuffle
    task automatic test_full_absorb();
        send_item(MODE_INIT, 8'h00);
        for (int n = 0; n < 64; n++) send_item(MODE_ABS, 8'($urandom));
        send_item(MODE_ABS, 8'($urandom));
        for (int n = 0; n < 63; n++) send_item(MODE_ABS, 8'($urandom));
        send_item(MODE_STOP, 8'($urandom));
        send_item(MODE_DRIP, 8'h00);
    endtask

    // random sponge sessions: init, short absorb, then mostly keystream items
    task automatic test_random(int total);
        int sent;
        int len;
        sent = 0;
        while (sent < total) begin
            if ($urandom_range(9) == 0) begin
                send_item(3'($urandom), 8'($urandom));
                sent++;
            end else begin
                send_item(MODE_INIT, 8'($urandom));
                len = $urandom_range(4);
                for (int n = 0; n < len; n++) begin
                    send_item($urandom_range(5) == 0 ? MODE_STOP : MODE_ABS, 8'($urandom));
                    sent++;
                end
                len = $urandom_range(20, 5);
                for (int n = 0; n < len; n++) begin
                    send_item(3'($urandom_range(7, 3)), 8'($urandom));
                    sent++;
                end
                sent++;
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        send_gap_pct = 16;
        recv_stall_pct = 72;
        state_clear();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_full_absorb();
        test_random(500);
        send_gap_pct = 72;
        recv_stall_pct = 16;
        test_random(500);
        send_gap_pct = 0;
        recv_stall_pct = 0;
        test_random(450);

        drain_results();
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("** spritz_sponge_cipher: PASSED **");
        else
            $display("** spritz_sponge_cipher: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
